// File: design/h64s_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// h64s_pkg
// Shared types, constants and round functions of the 64-bit SHA-1 style hash.
// ----------------------------------------------------------------------------
package h64s_pkg;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    localparam logic [31:0] INIT_HIGH = 32'h12345678;
    localparam logic [31:0] INIT_LOW  = 32'h90abcdef;

    localparam logic [31:0] K_CHOOSE = 32'h5a827999;
    localparam logic [31:0] K_PAR1   = 32'h6ed9eba1;
    localparam logic [31:0] K_MAJ    = 32'h8f1bbcdc;
    localparam logic [31:0] K_PAR2   = 32'hca62c1d6;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [7:0] PAD_ZERO = 8'h00;

    localparam logic [5:0] FILL_LAST  = 6'd63;
    localparam logic [5:0] FILL_LEN   = 6'd56;
    localparam logic [5:0] FILL_SIXTH = 6'd61;

    localparam logic [6:0] ROUND_LAST  = 7'd79;
    localparam logic [6:0] ROUND_SCHED = 7'd16;
    localparam logic [6:0] ROUND_PAR1  = 7'd20;
    localparam logic [6:0] ROUND_MAJ   = 7'd40;
    localparam logic [6:0] ROUND_PAR2  = 7'd60;

    localparam int WIN_DEPTH = 16;

    typedef struct packed {
        logic       finish;
        logic [7:0] data;
    } item_t;

    function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] w);
        logic [31:0] f;
        if (r < ROUND_PAR1) begin
            f = (b & c) | (~b & w);
        end else if (r >= ROUND_MAJ && r < ROUND_PAR2) begin
            f = (b & c) | (b & w) | (c & w);
        end else begin
            f = b ^ c ^ w;
        end
        return f;
    endfunction

    function automatic logic [31:0] round_k(input logic [6:0] r);
        logic [31:0] k;
        if (r < ROUND_PAR1) begin
            k = K_CHOOSE;
        end else if (r < ROUND_MAJ) begin
            k = K_PAR1;
        end else if (r < ROUND_PAR2) begin
            k = K_MAJ;
        end else begin
            k = K_PAR2;
        end
        return k;
    endfunction

endpackage
`default_nettype wire

// File: design/h64s_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// h64s_front
// Input side: takes words, tags them as data or finish, and buffers them in a
// two-entry queue toward the compression engine.
// ----------------------------------------------------------------------------
module h64s_front (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire logic           s_action,
    input  wire logic [7:0]     s_data_byte,
    output logic                q_valid,
    output h64s_pkg::item_t     q_item,
    input  wire logic           q_ready
);

    h64s_pkg::item_t                mem_reg [h64s_pkg::QDEPTH];
    logic [h64s_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [h64s_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [h64s_pkg::QCNT_W-1:0]    count_reg, count_next;
    logic                           push;
    logic                           pop;
    h64s_pkg::item_t                item_in;

    assign s_ready = (count_reg != h64s_pkg::QCNT_W'(h64s_pkg::QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        item_in.finish = s_action;
        item_in.data   = s_data_byte;
        wr_ptr_next    = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next    = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next     = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule
`default_nettype wire

// File: design/h64s_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// h64s_back
// Compression engine: packs bytes into the 16-word window, generates padding,
// runs 80 rounds one per cycle and holds the digest in an output register.
// ----------------------------------------------------------------------------
module h64s_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           q_valid,
    input  wire h64s_pkg::item_t q_item,
    output logic                q_ready,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic [63:0]         m_digest
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_FOLD  = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    localparam logic [2:0] PH_MARK = 3'd0;
    localparam logic [2:0] PH_ZERO = 3'd1;
    localparam logic [2:0] PH_SIX  = 3'd2;
    localparam logic [2:0] PH_HI   = 3'd3;
    localparam logic [2:0] PH_LO   = 3'd4;
    localparam logic [2:0] PH_DONE = 3'd5;

    logic [2:0]     state_reg, state_next;
    logic [2:0]     phase_reg, phase_next;
    logic           padding_reg, padding_next;
    logic [5:0]     fill_reg, fill_next;
    logic [12:0]    msg_reg, msg_next;
    logic [15:0]    bits_reg, bits_next;
    logic [6:0]     round_reg, round_next;
    logic [31:0]    chain_h_reg, chain_h_next;
    logic [31:0]    chain_l_reg, chain_l_next;
    logic [31:0]    work_a_reg, work_a_next;
    logic [31:0]    work_b_reg, work_b_next;
    logic [31:0]    win_reg [h64s_pkg::WIN_DEPTH];
    logic [31:0]    win_next [h64s_pkg::WIN_DEPTH];
    logic           m_valid_reg, m_valid_next;
    logic [63:0]    m_digest_reg, m_digest_next;

    logic           push_en;
    logic [7:0]     push_byte;
    logic           round_en;
    logic [31:0]    sched_x;
    logic [31:0]    w_t;
    logic           out_free;

    assign q_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_digest = m_digest_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign round_en = (state_reg == ST_ROUND);

    assign sched_x = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
    assign w_t     = (round_reg < h64s_pkg::ROUND_SCHED) ? win_reg[0]
                                                        : {sched_x[30:0], sched_x[31]};

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        padding_next  = padding_reg;
        fill_next     = fill_reg;
        msg_next      = msg_reg;
        bits_next     = bits_reg;
        round_next    = round_reg;
        chain_h_next  = chain_h_reg;
        chain_l_next  = chain_l_reg;
        work_a_next   = work_a_reg;
        work_b_next   = work_b_reg;
        m_digest_next = m_digest_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        push_en       = 1'b0;
        push_byte     = h64s_pkg::PAD_ZERO;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    if (q_item.finish) begin
                        bits_next    = {msg_reg, 3'b000};
                        padding_next = 1'b1;
                        phase_next   = PH_MARK;
                        state_next   = ST_PAD;
                    end else begin
                        push_en   = 1'b1;
                        push_byte = q_item.data;
                        msg_next  = msg_reg + 1'b1;
                    end
                end
            end
            ST_PAD: begin
                unique case (phase_reg)
                    PH_MARK: begin
                        push_en    = 1'b1;
                        push_byte  = h64s_pkg::PAD_MARK;
                        phase_next = PH_ZERO;
                    end
                    PH_ZERO: begin
                        if (fill_reg == h64s_pkg::FILL_LEN) begin
                            phase_next = PH_SIX;
                        end else begin
                            push_en = 1'b1;
                        end
                    end
                    PH_SIX: begin
                        push_en = 1'b1;
                        if (fill_reg == h64s_pkg::FILL_SIXTH) begin
                            phase_next = PH_HI;
                        end
                    end
                    PH_HI: begin
                        push_en    = 1'b1;
                        push_byte  = bits_reg[15:8];
                        phase_next = PH_LO;
                    end
                    PH_LO: begin
                        push_en    = 1'b1;
                        push_byte  = bits_reg[7:0];
                        phase_next = PH_DONE;
                    end
                    default: begin
                        phase_next = PH_DONE;
                    end
                endcase
            end
            ST_ROUND: begin
                work_a_next = h64s_pkg::round_f(round_reg, work_a_reg, work_b_reg, w_t)
                              + h64s_pkg::round_k(round_reg);
                work_b_next = {work_a_reg[1:0], work_a_reg[31:2]};
                round_next  = round_reg + 1'b1;
                if (round_reg == h64s_pkg::ROUND_LAST) begin
                    round_next = '0;
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                chain_h_next = chain_h_reg + work_a_reg;
                chain_l_next = chain_l_reg + work_b_reg;
                priority if (!padding_reg) begin
                    state_next = ST_IDLE;
                end else if (phase_reg == PH_DONE) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_PAD;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_digest_next = {chain_h_reg, chain_l_reg};
                    chain_h_next  = h64s_pkg::INIT_HIGH;
                    chain_l_next  = h64s_pkg::INIT_LOW;
                    msg_next      = '0;
                    fill_next     = '0;
                    padding_next  = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (push_en) begin
            fill_next = fill_reg + 1'b1;
            if (fill_reg == h64s_pkg::FILL_LAST) begin
                work_a_next = chain_h_reg;
                work_b_next = chain_l_reg;
                round_next  = '0;
                state_next  = ST_ROUND;
            end
        end
    end

    // window moves a byte per push, a word per round
    always_comb begin
        for (int i = 0; i < h64s_pkg::WIN_DEPTH; i++) begin
            win_next[i] = win_reg[i];
        end
        if (push_en) begin
            for (int i = 0; i < h64s_pkg::WIN_DEPTH - 1; i++) begin
                win_next[i] = {win_reg[i][23:0], win_reg[i+1][31:24]};
            end
            win_next[h64s_pkg::WIN_DEPTH-1] = {win_reg[h64s_pkg::WIN_DEPTH-1][23:0], push_byte};
        end else if (round_en) begin
            for (int i = 0; i < h64s_pkg::WIN_DEPTH - 1; i++) begin
                win_next[i] = win_reg[i+1];
            end
            win_next[h64s_pkg::WIN_DEPTH-1] = w_t;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_MARK;
            padding_reg <= 1'b0;
            fill_reg    <= '0;
            msg_reg     <= '0;
            round_reg   <= '0;
            chain_h_reg <= h64s_pkg::INIT_HIGH;
            chain_l_reg <= h64s_pkg::INIT_LOW;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            padding_reg <= padding_next;
            fill_reg    <= fill_next;
            msg_reg     <= msg_next;
            round_reg   <= round_next;
            chain_h_reg <= chain_h_next;
            chain_l_reg <= chain_l_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bits_reg     <= bits_next;
        work_a_reg   <= work_a_next;
        work_b_reg   <= work_b_next;
        m_digest_reg <= m_digest_next;
        for (int i = 0; i < h64s_pkg::WIN_DEPTH; i++) begin
            win_reg[i] <= win_next[i];
        end
    end

endmodule
`default_nettype wire

// File: design/hash64_sha1_style_core.sv
`default_nettype none
// Data word: a 64th byte starts a compression of 80 rounds, one per cycle,
// followed by the chaining add.
// Finish word: padding pushes the mark byte, zero bytes and the bit length,
// with one or two compressions; ST_OUT registers the digest once the output is free.
// The two-entry queue takes up to two words while the engine is busy, then drops s_ready.
// Synchronous active-low reset restores the initial chaining words and clears counts.
// ----------------------------------------------------------------------------
// hash64_sha1_style_core
// Byte-serial 64-bit SHA-1 style hash: input queue plus compression engine.
// ----------------------------------------------------------------------------
module hash64_sha1_style_core (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire logic           s_action,
    input  wire logic [7:0]     s_data_byte,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic [63:0]         m_digest
);

    logic               q_valid;
    logic               q_ready;
    h64s_pkg::item_t    q_item;

    h64s_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_data_byte (s_data_byte),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_ready     (q_ready)
    );

    h64s_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_ready  (q_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_digest (m_digest)
    );

endmodule
`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives byte and finish words into hash64_sha1_style_core with random gaps
// on both sides. A local model of the 64-bit hash predicts each digest, and
// the digests are compared in order against the DUT.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam bit ACT_ABSORB = 1'b0;
    localparam bit ACT_FINISH = 1'b1;

    localparam logic [31:0] SEED_HIGH = 32'h12345678;
    localparam logic [31:0] SEED_LOW  = 32'h90abcdef;
    localparam logic [31:0] K_R0      = 32'h5a827999;
    localparam logic [31:0] K_R20     = 32'h6ed9eba1;
    localparam logic [31:0] K_R40     = 32'h8f1bbcdc;
    localparam logic [31:0] K_R60     = 32'hca62c1d6;
    localparam logic [7:0]  PAD_BYTE  = 8'h80;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int RANDOM_WORDS   = 950;
    localparam int MIN_MESSAGES   = 40;
    localparam int LONG_HOLD      = 600;
    localparam int HOLD_AT_DIGEST = 20;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        bit       action;
        bit [7:0] data;
        bit       wait_idle;
    } word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_action = 1'b0;
    logic [7:0]  s_data_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_digest;

    word_t       pending_words[$];
    logic [63:0] digest_expected[$];

    logic [31:0] hash_high;
    logic [31:0] hash_low;
    logic [31:0] msg_window [16];
    logic [5:0]  block_bytes;
    logic [12:0] msg_length;

    int  words_accepted = 0;
    int  total_words = 0;
    int  digests_seen = 0;
    int  digest_errors = 0;
    int  send_gap = 0;
    bit  send_burst = 1'b0;
    int  ready_stall = 0;
    bit  ready_burst = 1'b0;
    bit  long_hold_done = 1'b0;
    bit  hold_active = 1'b0;
    int  idle_cycles = 0;
    int  boundary_lens [8] = '{55, 56, 57, 63, 64, 65, 119, 128};
    word_t       next_word;
    logic [63:0] want_digest;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    hash64_sha1_style_core DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_data_byte (s_data_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_digest    (m_digest)
    );

    function automatic logic [31:0] rotl1(input logic [31:0] x);
        return {x[30:0], x[31]};
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    task automatic clear_hash();
        hash_high = SEED_HIGH;
        hash_low = SEED_LOW;
        for (int i = 0; i < 16; i++) msg_window[i] = 32'h0;
        block_bytes = 6'd0;
        msg_length = 13'd0;
    endtask

    task automatic compress_block();
        logic [31:0] a, b, w, f, k, rot_a;
        logic [3:0]  slot;
        a = hash_high;
        b = hash_low;
        for (int r = 0; r < 80; r++) begin
            slot = r[3:0];
            if (r >= 16) begin
                w = rotl1(msg_window[slot - 4'd3] ^ msg_window[slot - 4'd8] ^
                          msg_window[slot - 4'd14] ^ msg_window[slot]);
                msg_window[slot] = w;
            end else begin
                w = msg_window[slot];
            end
            if (r < 20) begin
                f = (a & b) | (~a & w);
                k = K_R0;
            end else if (r < 40) begin
                f = a ^ b ^ w;
                k = K_R20;
            end else if (r < 60) begin
                f = (a & b) | (a & w) | (b & w);
                k = K_R40;
            end else begin
                f = a ^ b ^ w;
                k = K_R60;
            end
            rot_a = {a[1:0], a[31:2]};
            a = f + k;
            b = rot_a;
        end
        hash_high = hash_high + a;
        hash_low = hash_low + b;
    endtask

    task automatic absorb_byte(input logic [7:0] value);
        logic [3:0] idx;
        idx = block_bytes[5:2];
        msg_window[idx] = {msg_window[idx][23:0], value};
        block_bytes = block_bytes + 6'd1;
        if (block_bytes == 6'd0) compress_block();
    endtask

    task automatic hash_word(input bit action, input logic [7:0] value);
        logic [15:0] bit_len;
        if (action == ACT_ABSORB) begin
            absorb_byte(value);
            msg_length = msg_length + 13'd1;
        end else begin
            bit_len = {msg_length, 3'b000};
            absorb_byte(PAD_BYTE);
            while (block_bytes != 6'd56) absorb_byte(8'h00);
            repeat (6) absorb_byte(8'h00);
            absorb_byte(bit_len[15:8]);
            absorb_byte(bit_len[7:0]);
            digest_expected.push_back({hash_high, hash_low});
            clear_hash();
        end
    endtask

    task automatic put_word(input bit action, input logic [7:0] value, input bit wait_idle);
        word_t w;
        w.action = action;
        w.data = value;
        w.wait_idle = wait_idle;
        pending_words.push_back(w);
    endtask

    task automatic queue_message(input int len, input bit wait_idle);
        for (int i = 0; i < len; i++) put_word(ACT_ABSORB, 8'($urandom), wait_idle && i == 0);
        put_word(ACT_FINISH, 8'($urandom), wait_idle && len == 0);
    endtask

    initial begin
        int n_rand;
        int n_msgs;
        int len;
        int pick;
        clear_hash();

        // empty and short messages, back to back
        put_word(ACT_FINISH, 8'h00, 1'b0);
        put_word(ACT_FINISH, 8'hff, 1'b0);
        put_word(ACT_ABSORB, 8'h00, 1'b0);
        put_word(ACT_FINISH, 8'h00, 1'b0);
        put_word(ACT_ABSORB, 8'hff, 1'b0);
        put_word(ACT_FINISH, 8'hff, 1'b0);
        put_word(ACT_ABSORB, 8'h00, 1'b0);
        put_word(ACT_ABSORB, 8'hff, 1'b0);
        put_word(ACT_ABSORB, 8'h80, 1'b0);
        put_word(ACT_ABSORB, 8'h7f, 1'b0);
        put_word(ACT_ABSORB, 8'h55, 1'b0);
        put_word(ACT_ABSORB, 8'haa, 1'b0);
        put_word(ACT_FINISH, 8'h5a, 1'b0);

        n_rand = 0;
        n_msgs = 0;
        while (n_rand < RANDOM_WORDS || n_msgs < MIN_MESSAGES) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) len = $urandom_range(0, 12);
            else if (pick < 85) len = boundary_lens[$urandom_range(0, 7)];
            else len = $urandom_range(13, 100);
            queue_message(len, n_msgs == 0 || $urandom_range(0, 9) == 0);
            n_rand += len + 1;
            n_msgs++;
        end
        total_words = pending_words.size();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        do @(posedge aclk);
        while (words_accepted != total_words || digest_expected.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (digest_errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_action <= ACT_ABSORB;
            s_data_byte <= 8'h00;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                hash_word(s_action, s_data_byte);
                words_accepted++;
                send_gap = send_burst ? 0 : pick_gap();
                if ($urandom_range(0, 99) == 0) send_burst = !send_burst;
            end
            if (!s_valid || s_ready) begin
                if (send_gap == 0 && pending_words.size() != 0 &&
                    !(pending_words[0].wait_idle && digest_expected.size() != 0 &&
                      !hold_active)) begin
                    next_word = pending_words.pop_front();
                    s_valid <= 1'b1;
                    s_action <= next_word.action;
                    s_data_byte <= next_word.data;
                end else begin
                    s_valid <= 1'b0;
                    if (send_gap > 0) send_gap--;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            ready_stall = 0;
        end else begin
            if (m_valid && m_ready) begin
                digests_seen++;
                if (digest_expected.size() == 0) begin
                    digest_errors++;
                    if (digest_errors <= MAX_REPORTS)
                        $display("unexpected digest: actual %h", m_digest);
                end else begin
                    want_digest = digest_expected.pop_front();
                    if (m_digest !== want_digest) begin
                        digest_errors++;
                        if (digest_errors <= MAX_REPORTS)
                            $display("digest mismatch: expected %h actual %h",
                                     want_digest, m_digest);
                    end
                end
            end
            if (ready_stall > 0) begin
                ready_stall--;
                if (ready_stall == 0) hold_active = 1'b0;
                m_ready <= 1'b0;
            end else if (digests_seen == HOLD_AT_DIGEST && !long_hold_done) begin
                // long back-pressure so the input side fills and stalls
                long_hold_done = 1'b1;
                hold_active = 1'b1;
                ready_stall = LONG_HOLD;
                m_ready <= 1'b0;
            end else if (ready_burst) begin
                m_ready <= 1'b1;
            end else if ($urandom_range(0, 99) < 8) begin
                ready_stall = pick_gap();
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 199) == 0) ready_burst = !ready_burst;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
